/* hdl/epvt_pkg.sv */
// Shared constants, state encoding and controller/datapath interface types.
`default_nettype none
package epvt_pkg;

    localparam int POOL_SLOTS_DEF = 8;
    localparam int MAX_OPS_DEF    = 256;
    localparam int MAX_ALTS_DEF   = 8;

    localparam int ALT_W       = 3;
    localparam int OP_W        = 8;
    localparam int SPAN_W      = 16;
    localparam int SLOT_OUT_W  = 3;
    localparam int OPS_CFG_W   = 9;
    localparam int CAP_CFG_W   = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 32;

    localparam logic [SPAN_W-1:0] SPAN_NONE = 16'hFFFF;

    localparam logic [OPS_CFG_W-1:0] OPS_RESET = 9'd256;
    localparam logic [CAP_CFG_W-1:0] CAP_RESET = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_OPS_IN_USE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_CAPACITY = 2'd1;

    localparam logic KIND_ELEMENT = 1'b0;
    localparam logic KIND_QUERY   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_E_RD,
        ST_E_CMP,
        ST_DECIDE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_REPL,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_Q_RD,
        ST_Q_CNT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic elem_upd;
        logic decide;
        logic scan_cmp;
        logic repl;
        logic copy_wr;
        logic vote_cnt;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic len_err;
        logic dup;
        logic has_free;
        logic scan_done;
        logic span_better;
        logic copy_done;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

/* hdl/epvt_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module epvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* hdl/epvt_ctrl.sv */
// Sequencing state machine for element, commit, copy and query transactions.
`default_nettype none
module epvt_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tuser,
    output logic                   s_tready,
    input  wire epvt_pkg::status_t status,
    output epvt_pkg::cmd_t         cmd
);

    epvt_pkg::state_t state_reg;
    epvt_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= epvt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            epvt_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == epvt_pkg::KIND_QUERY) ?
                                 epvt_pkg::ST_Q_RD : epvt_pkg::ST_E_RD;
                end
            end
            epvt_pkg::ST_E_RD:  state_next = epvt_pkg::ST_E_CMP;
            epvt_pkg::ST_E_CMP: begin
                state_next = status.last ? epvt_pkg::ST_DECIDE : epvt_pkg::ST_IDLE;
            end
            epvt_pkg::ST_DECIDE: begin
                if (status.len_err || status.dup) begin
                    state_next = epvt_pkg::ST_OUT;
                end else if (status.has_free) begin
                    state_next = epvt_pkg::ST_COPY_RD;
                end else begin
                    state_next = epvt_pkg::ST_SCAN_RD;
                end
            end
            epvt_pkg::ST_SCAN_RD:  state_next = epvt_pkg::ST_SCAN_CMP;
            epvt_pkg::ST_SCAN_CMP: begin
                state_next = status.scan_done ? epvt_pkg::ST_REPL : epvt_pkg::ST_SCAN_RD;
            end
            epvt_pkg::ST_REPL: begin
                state_next = status.span_better ? epvt_pkg::ST_COPY_RD : epvt_pkg::ST_OUT;
            end
            epvt_pkg::ST_COPY_RD: state_next = epvt_pkg::ST_COPY_WR;
            epvt_pkg::ST_COPY_WR: begin
                state_next = status.copy_done ? epvt_pkg::ST_OUT : epvt_pkg::ST_COPY_RD;
            end
            epvt_pkg::ST_Q_RD:  state_next = epvt_pkg::ST_Q_CNT;
            epvt_pkg::ST_Q_CNT: state_next = epvt_pkg::ST_OUT;
            epvt_pkg::ST_OUT: begin
                if (status.out_free) begin
                    state_next = epvt_pkg::ST_IDLE;
                end
            end
            default: state_next = epvt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = (state_reg == epvt_pkg::ST_IDLE);
        cmd           = '0;
        cmd.load_item = (state_reg == epvt_pkg::ST_IDLE) && s_tvalid;
        cmd.elem_upd  = (state_reg == epvt_pkg::ST_E_CMP);
        cmd.decide    = (state_reg == epvt_pkg::ST_DECIDE);
        cmd.scan_cmp  = (state_reg == epvt_pkg::ST_SCAN_CMP);
        cmd.repl      = (state_reg == epvt_pkg::ST_REPL);
        cmd.copy_wr   = (state_reg == epvt_pkg::ST_COPY_WR);
        cmd.vote_cnt  = (state_reg == epvt_pkg::ST_Q_CNT);
        cmd.out_load  = (state_reg == epvt_pkg::ST_OUT) && status.out_free;
    end

endmodule
`default_nettype wire

/* hdl/epvt_dp.sv */
// Datapath: pool storage, match tracking, replacement search, copy and vote count.
`default_nettype none
module epvt_dp #(
    parameter int POOL_SLOTS = epvt_pkg::POOL_SLOTS_DEF,
    parameter int MAX_OPS    = epvt_pkg::MAX_OPS_DEF,
    parameter int MAX_ALTS   = epvt_pkg::MAX_ALTS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire epvt_pkg::cmd_t                      cmd,
    output epvt_pkg::status_t                        status,
    input  wire logic [epvt_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic                                s_tuser,
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [epvt_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                     m_tuser,
    input  wire logic                                cfg_we,
    input  wire logic [epvt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [epvt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ALT_W     = epvt_pkg::ALT_W;
    localparam int SPAN_W    = epvt_pkg::SPAN_W;
    localparam int SLOT_W    = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int FILL_W    = $clog2(POOL_SLOTS + 1);
    localparam int OPS_AW    = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam int POS_W     = $clog2(MAX_OPS + 1);
    localparam int VOTE_ALTS = (MAX_ALTS < 8) ? MAX_ALTS : 8;
    localparam int VA_W      = $clog2(VOTE_ALTS);

    // configuration
    logic [epvt_pkg::OPS_CFG_W-1:0] ops_cfg_reg;
    logic [epvt_pkg::CAP_CFG_W-1:0] cap_cfg_reg;
    logic [POS_W-1:0]               n_eff;
    logic [FILL_W-1:0]              cap_eff;

    // latched item
    logic                        kind_reg;
    logic                        last_reg;
    logic [ALT_W-1:0]            alt_reg;
    logic [epvt_pkg::OP_W-1:0]   op_reg;
    logic [SPAN_W-1:0]           span_reg;

    // pool control state
    logic [POS_W-1:0]      pos_reg;
    logic [POOL_SLOTS-1:0] match_reg;
    logic                  lerr_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [SPAN_W-1:0]     best_reg;
    logic [POS_W-1:0]      vote_ops_reg;
    logic [SLOT_W-1:0]     scan_idx_reg;
    logic [SLOT_W-1:0]     worst_idx_reg;
    logic [SPAN_W-1:0]     worst_span_reg;
    logic [OPS_AW-1:0]     copy_idx_reg;
    logic [SLOT_W-1:0]     commit_slot_reg;

    // result
    logic                  res_acc_reg;
    logic                  res_dup_reg;
    logic                  res_lerr_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic [FILL_W-1:0]     cnt_reg [VOTE_ALTS];
    logic [FILL_W-1:0]     cnt_next [VOTE_ALTS];
    logic                  q_inuse_reg;
    logic                  m_tvalid_reg;
    logic [epvt_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                  m_tuser_reg;
    logic [epvt_pkg::M_TDATA_W-1:0] out_word;

    logic [ALT_W-1:0]      alt_sat;
    logic                  elem_in;
    logic [OPS_AW-1:0]     pos_addr;
    logic [OPS_AW-1:0]     route_raddr;
    logic [ALT_W-1:0]      route_rdata [POOL_SLOTS];
    logic [ALT_W-1:0]      inc_rdata;
    logic [SPAN_W-1:0]     span_rdata;
    logic [POOL_SLOTS-1:0] fill_mask;
    logic [POOL_SLOTS-1:0] match_next;
    logic                  dup;
    logic                  has_free;
    logic                  commit_now;
    logic [SLOT_W-1:0]     commit_sel;
    logic [VA_W-1:0]       top_idx;
    logic [FILL_W-1:0]     top_cnt;
    logic [ALT_W-1:0]      top_alt;
    logic                  out_free;

    always_comb begin
        if (ops_cfg_reg == '0) begin
            n_eff = POS_W'(1);
        end else if (int'(ops_cfg_reg) > MAX_OPS) begin
            n_eff = POS_W'(MAX_OPS);
        end else begin
            n_eff = POS_W'(ops_cfg_reg);
        end
        if (cap_cfg_reg == '0) begin
            cap_eff = FILL_W'(1);
        end else if (int'(cap_cfg_reg) > POOL_SLOTS) begin
            cap_eff = FILL_W'(POOL_SLOTS);
        end else begin
            cap_eff = FILL_W'(cap_cfg_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ops_cfg_reg <= epvt_pkg::OPS_RESET;
            cap_cfg_reg <= epvt_pkg::CAP_RESET;
        end else if (cfg_we) begin
            if (cfg_index == epvt_pkg::REG_OPS_IN_USE) begin
                ops_cfg_reg <= cfg_data;
            end else if (cfg_index == epvt_pkg::REG_POOL_CAPACITY) begin
                cap_cfg_reg <= cfg_data[epvt_pkg::CAP_CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg <= s_tuser;
            last_reg <= s_tlast;
            alt_reg  <= s_tdata[2:0];
            op_reg   <= s_tdata[10:3];
            span_reg <= s_tdata[26:11];
        end
    end

    assign alt_sat     = (int'(alt_reg) > MAX_ALTS - 1) ? ALT_W'(MAX_ALTS - 1) : alt_reg;
    assign elem_in     = (pos_reg < n_eff);
    assign pos_addr    = pos_reg[OPS_AW-1:0];
    assign route_raddr = (kind_reg == epvt_pkg::KIND_QUERY) ? OPS_AW'(op_reg) : pos_addr;

    always_comb begin
        for (int s = 0; s < POOL_SLOTS; s++) begin
            fill_mask[s]  = (FILL_W'(s) < fill_reg);
            match_next[s] = match_reg[s] && !(elem_in && (route_rdata[s] != alt_sat));
        end
    end

    assign dup        = |(match_reg & fill_mask);
    assign has_free   = (fill_reg < cap_eff);
    assign commit_now = (cmd.decide && !lerr_reg && !dup && has_free) ||
                        (cmd.repl && status.span_better);
    assign commit_sel = cmd.repl ? worst_idx_reg : SLOT_W'(fill_reg);
    assign out_free   = !m_tvalid_reg || m_tready;

    // routing storage, one RAM per slot so every slot is read at the same operation
    for (genvar g = 0; g < POOL_SLOTS; g++) begin : g_route
        epvt_ram #(
            .WIDTH (ALT_W),
            .DEPTH (MAX_OPS)
        ) u_route (
            .aclk  (aclk),
            .we    (cmd.copy_wr && (commit_slot_reg == SLOT_W'(g))),
            .waddr (copy_idx_reg),
            .wdata (inc_rdata),
            .raddr (route_raddr),
            .rdata (route_rdata[g])
        );
    end

    epvt_ram #(
        .WIDTH (ALT_W),
        .DEPTH (MAX_OPS)
    ) u_incoming (
        .aclk  (aclk),
        .we    (cmd.elem_upd && elem_in),
        .waddr (pos_addr),
        .wdata (alt_sat),
        .raddr (copy_idx_reg),
        .rdata (inc_rdata)
    );

    epvt_ram #(
        .WIDTH (SPAN_W),
        .DEPTH (POOL_SLOTS)
    ) u_spans (
        .aclk  (aclk),
        .we    (commit_now),
        .waddr (commit_sel),
        .wdata (span_reg),
        .raddr (scan_idx_reg),
        .rdata (span_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            match_reg    <= '1;
            lerr_reg     <= 1'b0;
            fill_reg     <= '0;
            best_reg     <= epvt_pkg::SPAN_NONE;
            vote_ops_reg <= '0;
            scan_idx_reg <= '0;
            copy_idx_reg <= '0;
        end else begin
            if (cmd.elem_upd) begin
                match_reg <= match_next;
                lerr_reg  <= ({1'b0, pos_reg} + (POS_W+1)'(1)) != {1'b0, n_eff};
                if (int'(pos_reg) < MAX_OPS) begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
            if (cmd.decide) begin
                pos_reg      <= '0;
                match_reg    <= '1;
                scan_idx_reg <= '0;
                copy_idx_reg <= '0;
                if (commit_now) begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end
            if (commit_now) begin
                best_reg     <= (span_reg < best_reg) ? span_reg : best_reg;
                vote_ops_reg <= n_eff;
            end
            if (cmd.scan_cmp && !status.scan_done) begin
                scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
            end
            if (cmd.copy_wr) begin
                copy_idx_reg <= copy_idx_reg + OPS_AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_cmp) begin
            if (scan_idx_reg == '0 || span_rdata > worst_span_reg) begin
                worst_span_reg <= span_rdata;
                worst_idx_reg  <= scan_idx_reg;
            end
        end
        if (commit_now) begin
            commit_slot_reg <= commit_sel;
        end
        if (cmd.decide) begin
            res_lerr_reg <= lerr_reg;
            res_dup_reg  <= !lerr_reg && dup;
            res_acc_reg  <= commit_now;
            res_slot_reg <= commit_now ? commit_sel : '0;
        end
        if (cmd.repl) begin
            res_acc_reg  <= commit_now;
            res_slot_reg <= commit_now ? commit_sel : '0;
        end
    end

    // votes of one operation, counted over the held slots
    always_comb begin
        for (int a = 0; a < VOTE_ALTS; a++) begin
            cnt_next[a] = '0;
            for (int s = 0; s < POOL_SLOTS; s++) begin
                if (fill_mask[s] && (route_rdata[s] == ALT_W'(a))) begin
                    cnt_next[a] = cnt_next[a] + FILL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.vote_cnt) begin
            cnt_reg     <= cnt_next;
            q_inuse_reg <= (int'(op_reg) < int'(n_eff)) && (int'(op_reg) < int'(vote_ops_reg));
        end
    end

    always_comb begin
        top_idx = '0;
        top_cnt = cnt_reg[0];
        for (int a = 1; a < VOTE_ALTS; a++) begin
            if (cnt_reg[a] > top_cnt) begin
                top_cnt = cnt_reg[a];
                top_idx = VA_W'(a);
            end
        end
        top_alt = q_inuse_reg ? ALT_W'(top_idx) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_comb begin
        out_word        = '0;
        out_word[21:6]  = best_reg;
        if (kind_reg == epvt_pkg::KIND_QUERY) begin
            out_word[24:22] = top_alt;
        end else begin
            out_word[0]     = res_acc_reg;
            out_word[1]     = res_dup_reg;
            out_word[2]     = res_lerr_reg;
            out_word[5:3]   = epvt_pkg::SLOT_OUT_W'(res_slot_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= out_word;
            if (kind_reg == epvt_pkg::KIND_QUERY) begin
                m_tuser_reg <= epvt_pkg::KIND_QUERY;
            end else begin
                m_tuser_reg <= epvt_pkg::KIND_ELEMENT;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        status             = '0;
        status.last        = last_reg;
        status.len_err     = lerr_reg;
        status.dup         = dup;
        status.has_free    = has_free;
        status.scan_done   = (FILL_W'(scan_idx_reg) + FILL_W'(1)) == fill_reg;
        status.span_better = (span_reg < worst_span_reg);
        status.copy_done   = (POS_W'(copy_idx_reg) + POS_W'(1)) == n_eff;
        status.out_free    = out_free;
    end

endmodule
`default_nettype wire

/* hdl/elite_pool_vote_tracker.sv */
// Top level of the elite pool with per-operation alternative votes.
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    tdata: alternative, op_index, makespan; tuser kind; tlast
// m_       out  m_tvalid/m_tready    tdata: outcome flags, slot, best, top alt; tuser kind
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A candidate element passes through accept, slot read and compare steps. A query passes
// through accept, read, count and output steps. The last element adds a decision and an
// output step; a full pool adds a read and compare per held slot for the worst-entry scan
// plus a replacement step, and an accepted routing adds a copy read and write per operation.
// Reset is synchronous; vote counts derive from held routings, so no clearing pass.
// A result waiting on m_tready holds the state machine in its output step.
`default_nettype none
module elite_pool_vote_tracker #(
    parameter int POOL_SLOTS = epvt_pkg::POOL_SLOTS_DEF,
    parameter int MAX_OPS    = epvt_pkg::MAX_OPS_DEF,
    parameter int MAX_ALTS   = epvt_pkg::MAX_ALTS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [2:0] alternative, [10:3] op_index, [26:11] makespan
    input  wire logic [epvt_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] kind
    input  wire logic                            s_tuser,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] accepted, [1] duplicate, [2] length_error, [5:3] slot,
    // [21:6] best_makespan, [24:22] top_alternative
    output logic      [epvt_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] answer_kind
    output logic                                 m_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [epvt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [epvt_pkg::CFG_DATA_W-1:0] cfg_data
);

    epvt_pkg::cmd_t    cmd;
    epvt_pkg::status_t status;

    assign cfg_ready = 1'b1;

    epvt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    epvt_dp #(
        .POOL_SLOTS (POOL_SLOTS),
        .MAX_OPS    (MAX_OPS),
        .MAX_ALTS   (MAX_ALTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("transaction accepted while one is in flight");

    a_query_flags_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[5:0] == 6'd0))
        else $error("query answer carries candidate outcome bits");

    a_outcome_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |->
        ($countones(m_tdata[2:0]) <= 1 && m_tdata[24:22] == 3'd0))
        else $error("candidate outcome bits inconsistent");

    a_slot_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[5:3] == 3'd0))
        else $error("slot reported for a rejected candidate");

endmodule
`default_nettype wire
